// ----- sv/cmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Color matte removal package
// Shared types, constants and register codes for the matte removal block.
// ----------------------------------------------------------------------------
package cmr_pkg;

	typedef logic [7:0] pix_t;

	localparam pix_t PIX_MAX   = 8'd255;
	localparam pix_t ALPHA_MIN = 8'd3;

	// The quotient is 8 bits wide; one divider stage resolves one bit.
	localparam int DIV_STAGES = 8;
	// Lane latency: product stage, difference stage, then the divider stages.
	localparam int LANE_LAT   = DIV_STAGES + 2;
	// Accept edge to the edge at which the result is taken.
	localparam int OUT_LAT    = LANE_LAT + 1;

	typedef enum logic [7:0] {
		REG_MATTE_MODE   = 8'd0,
		REG_CUSTOM_RED   = 8'd1,
		REG_CUSTOM_GREEN = 8'd2,
		REG_CUSTOM_BLUE  = 8'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		MATTE_BLACK  = 2'd0,
		MATTE_WHITE  = 2'd1,
		MATTE_CUSTOM = 2'd2
	} matte_mode_t;

	typedef struct packed {
		logic valid;
		pix_t alpha;
	} ctl_t;

endpackage

// ----- sv/cmr_lane.sv -----
// ----------------------------------------------------------------------------
// Color matte removal lane
// One color channel: forms 255*C - B*(255-A) and divides it by A in a
// pipelined restoring divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module cmr_lane (
	input  logic         clk,
	input  cmr_pkg::pix_t chan,
	input  cmr_pkg::pix_t matte,
	input  cmr_pkg::pix_t alpha,
	output cmr_pkg::pix_t result
);
	import cmr_pkg::*;

	pix_t        chan_s1;
	pix_t        alpha_s1;
	logic        pass_s1;
	logic [15:0] pos_s1;
	logic [15:0] neg_s1;
	logic [16:0] diff;

	// Divider pipeline; index 0 is the difference stage, index i the stage
	// after i quotient bits have been resolved.
	logic [15:0] rem_s  [0:DIV_STAGES];
	pix_t        q_s    [0:DIV_STAGES];
	pix_t        a_s    [0:DIV_STAGES];
	pix_t        c_s    [0:DIV_STAGES];
	logic        pass_s [0:DIV_STAGES];
	logic        zero_s [0:DIV_STAGES];
	logic        sat_s  [0:DIV_STAGES];

	always_ff @(posedge clk) begin
		chan_s1  <= chan;
		alpha_s1 <= alpha;
		pass_s1  <= (alpha < ALPHA_MIN);
		pos_s1   <= {chan, 8'h00} - {8'h00, chan};
		neg_s1   <= 16'(matte) * 16'(PIX_MAX - alpha);
	end

	assign diff = {1'b0, pos_s1} - {1'b0, neg_s1};

	always_ff @(posedge clk) begin
		rem_s[0]  <= diff[15:0];
		q_s[0]    <= '0;
		a_s[0]    <= alpha_s1;
		c_s[0]    <= chan_s1;
		pass_s[0] <= pass_s1;
		zero_s[0] <= diff[16];
		// Anything at or above 256*A would give a quotient beyond the range.
		sat_s[0]  <= (diff[15:0] >= {alpha_s1, 8'h00});
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		localparam int K = DIV_STAGES - 1 - i;
		logic [16:0] trial;

		assign trial = {1'b0, rem_s[i]} - (17'(a_s[i]) << K);

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= trial[16] ? rem_s[i] : trial[15:0];
			q_s[i+1]    <= {q_s[i][6:0], ~trial[16]};
			a_s[i+1]    <= a_s[i];
			c_s[i+1]    <= c_s[i];
			pass_s[i+1] <= pass_s[i];
			zero_s[i+1] <= zero_s[i];
			sat_s[i+1]  <= sat_s[i];
		end
	end

	always_comb begin
		if (pass_s[DIV_STAGES]) begin
			result = c_s[DIV_STAGES];
		end else if (zero_s[DIV_STAGES]) begin
			result = '0;
		end else if (sat_s[DIV_STAGES]) begin
			result = PIX_MAX;
		end else begin
			result = q_s[DIV_STAGES];
		end
	end

endmodule

// ----- sv/cmr_merge.sv -----
// ----------------------------------------------------------------------------
// Color matte removal merge stage
// Joins the three lane results with the carried alpha into the output
// register and raises the result strobe.
// ----------------------------------------------------------------------------
module cmr_merge (
	input  logic          clk,
	input  logic          arst_n,
	input  cmr_pkg::ctl_t ctl,
	input  cmr_pkg::pix_t red_res,
	input  cmr_pkg::pix_t green_res,
	input  cmr_pkg::pix_t blue_res,
	output logic          done,
	output cmr_pkg::pix_t red_out,
	output cmr_pkg::pix_t green_out,
	output cmr_pkg::pix_t blue_out,
	output cmr_pkg::pix_t alpha_out
);
	import cmr_pkg::*;

	logic done_q;
	pix_t red_q;
	pix_t green_q;
	pix_t blue_q;
	pix_t alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= red_res;
		green_q <= green_res;
		blue_q  <= blue_res;
		alpha_q <= ctl.alpha;
	end

	assign done      = done_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = alpha_q;

endmodule

// ----- sv/color_matte_removal.sv -----
// ----------------------------------------------------------------------------
// Color matte removal
// Removes a black, white or custom matte color from RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
// A pixel is taken on each rising edge with start high and busy low. Busy
// never rises, so one pixel can be taken on every clock.
// Each pixel yields one result, shown for one cycle with done high.
// Results come out in order, one per clock at most.
// The latency is set by the per-channel restoring divider: one product
// stage, one difference stage, eight quotient-bit stages and the output
// register. Red, green and blue each have a lane of their own.
// The matte registers are written through cfg_valid/cfg_ready, cfg_index and
// cfg_data; cfg_ready is always high. Write them only while no pixel is in
// flight. Indexes beyond the register list are ignored.
// Reset clears the registers (black matte) and drops any pixel in flight.
// The receiver cannot stall: a result must be taken in its done cycle.
// ----------------------------------------------------------------------------
module color_matte_removal (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cmr_pkg::pix_t red_in,
	input  cmr_pkg::pix_t green_in,
	input  cmr_pkg::pix_t blue_in,
	input  cmr_pkg::pix_t alpha_in,
	output logic          done,
	output cmr_pkg::pix_t red_out,
	output cmr_pkg::pix_t green_out,
	output cmr_pkg::pix_t blue_out,
	output cmr_pkg::pix_t alpha_out,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	import cmr_pkg::*;

	matte_mode_t mode_q;
	pix_t        cust_red_q;
	pix_t        cust_green_q;
	pix_t        cust_blue_q;
	pix_t        matte_red;
	pix_t        matte_green;
	pix_t        matte_blue;
	pix_t        red_res;
	pix_t        green_res;
	pix_t        blue_res;
	logic        accept;
	ctl_t        ctl_s [0:LANE_LAT-1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MATTE_BLACK;
			cust_red_q   <= '0;
			cust_green_q <= '0;
			cust_blue_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MATTE_MODE:   mode_q       <= matte_mode_t'(cfg_data[1:0]);
				REG_CUSTOM_RED:   cust_red_q   <= cfg_data;
				REG_CUSTOM_GREEN: cust_green_q <= cfg_data;
				REG_CUSTOM_BLUE:  cust_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The unused mode code selects the custom color, like the custom mode.
	always_comb begin
		case (mode_q)
			MATTE_BLACK: begin
				matte_red   = '0;
				matte_green = '0;
				matte_blue  = '0;
			end
			MATTE_WHITE: begin
				matte_red   = PIX_MAX;
				matte_green = PIX_MAX;
				matte_blue  = PIX_MAX;
			end
			default: begin
				matte_red   = cust_red_q;
				matte_green = cust_green_q;
				matte_blue  = cust_blue_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				ctl_s[i] <= '0;
			end
		end else begin
			ctl_s[0] <= '{valid: accept, alpha: alpha_in};
			for (int i = 1; i < LANE_LAT; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	cmr_lane u_lane_red (
		.clk    (clk),
		.chan   (red_in),
		.matte  (matte_red),
		.alpha  (alpha_in),
		.result (red_res)
	);

	cmr_lane u_lane_green (
		.clk    (clk),
		.chan   (green_in),
		.matte  (matte_green),
		.alpha  (alpha_in),
		.result (green_res)
	);

	cmr_lane u_lane_blue (
		.clk    (clk),
		.chan   (blue_in),
		.matte  (matte_blue),
		.alpha  (alpha_in),
		.result (blue_res)
	);

	cmr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s[LANE_LAT-1]),
		.red_res   (red_res),
		.green_res (green_res),
		.blue_res  (blue_res),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

endmodule

// ----- sv/cmr_checker.sv -----
// ----------------------------------------------------------------------------
// Color matte removal checker
// Port-level checks on result timing and pass-through behavior.
// ----------------------------------------------------------------------------
module cmr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input cmr_pkg::pix_t red_in,
	input cmr_pkg::pix_t alpha_in,
	input logic          done,
	input cmr_pkg::pix_t red_out,
	input cmr_pkg::pix_t alpha_out
);
	import cmr_pkg::*;

	// Every result belongs to an item taken a fixed number of cycles earlier.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("result without a matching item");

	a_alpha_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> alpha_out == $past(alpha_in, OUT_LAT))
		else $error("alpha not passed through");

	// Nearly transparent pixels leave the block unchanged.
	a_low_alpha_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alpha_out < ALPHA_MIN) |-> red_out == $past(red_in, OUT_LAT))
		else $error("low-alpha pixel was altered");

	// An opaque pixel carries no matte, so its color comes back unchanged.
	a_opaque_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alpha_out == PIX_MAX) |-> red_out == $past(red_in, OUT_LAT))
		else $error("opaque pixel was altered");

endmodule

bind color_matte_removal cmr_checker u_cmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.red_in    (red_in),
	.alpha_in  (alpha_in),
	.done      (done),
	.red_out   (red_out),
	.alpha_out (alpha_out)
);

// ----- verif/color_matte_removal_test.sv -----
// ----------------------------------------------------------------------------
// Color matte removal testbench
// Streams RGBA pixels through the block under several matte settings, with
// random start gaps and bursts, and checks every result in order against an
// integer model of the unpremultiply and clamp.
// ----------------------------------------------------------------------------
module color_matte_removal_test;
	import cmr_pkg::*;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		pix_t alpha;
	} rgba_t;

	typedef struct {
		logic [7:0] mode_data;
		pix_t       red;
		pix_t       green;
		pix_t       blue;
		bit         poke_unmapped;
	} matte_setting_t;

	localparam logic [7:0] UNMAPPED_LOW    = 8'd4;
	localparam logic [7:0] UNMAPPED_HIGH   = 8'd255;
	localparam int         NUM_SETTINGS    = 8;
	localparam int         RANDOM_PER_SET  = 115;
	localparam int         CYCLE_LIMIT     = 400000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic       start     = 1'b0;
	pix_t       red_in    = '0;
	pix_t       green_in  = '0;
	pix_t       blue_in   = '0;
	pix_t       alpha_in  = '0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	logic busy;
	logic done;
	logic cfg_ready;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;
	pix_t alpha_out;

	color_matte_removal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Matte registers as the block should hold them.
	logic [1:0] mode_cfg  = MATTE_BLACK;
	pix_t       red_cfg   = '0;
	pix_t       green_cfg = '0;
	pix_t       blue_cfg  = '0;

	rgba_t pixel_q[$];
	rgba_t restored_q[$];

	logic pix_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int   gap_left  = 0;
	int   burst_left = 0;
	int   errors    = 0;
	int   checked   = 0;
	int   low_alpha = 0;
	int   cycles    = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic pix_t restore_channel(pix_t c, pix_t m, pix_t a);
		int lit;
		int matte_part;
		int q;
		lit        = int'(PIX_MAX) * int'(c);
		matte_part = int'(m) * (int'(PIX_MAX) - int'(a));
		if (lit < matte_part)
			return '0;
		q = (lit - matte_part) / int'(a);
		return (q > int'(PIX_MAX)) ? PIX_MAX : pix_t'(q);
	endfunction

	function automatic rgba_t unmatte_pixel(rgba_t px);
		rgba_t res;
		pix_t  mr;
		pix_t  mg;
		pix_t  mb;
		case (mode_cfg)
			MATTE_BLACK: begin
				mr = '0; mg = '0; mb = '0;
			end
			MATTE_WHITE: begin
				mr = PIX_MAX; mg = PIX_MAX; mb = PIX_MAX;
			end
			// The spare mode value behaves like the custom matte.
			default: begin
				mr = red_cfg; mg = green_cfg; mb = blue_cfg;
			end
		endcase
		res = px;
		if (px.alpha >= ALPHA_MIN) begin
			res.red   = restore_channel(px.red, mr, px.alpha);
			res.green = restore_channel(px.green, mg, px.alpha);
			res.blue  = restore_channel(px.blue, mb, px.alpha);
		end
		return res;
	endfunction

	function automatic pix_t random_channel();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return PIX_MAX;
		return pix_t'($urandom_range(0, 255));
	endfunction

	function automatic rgba_t random_pixel();
		rgba_t px;
		int    roll;
		px.red   = random_channel();
		px.green = random_channel();
		px.blue  = random_channel();
		roll = $urandom_range(0, 7);
		if (roll == 0)
			px.alpha = pix_t'($urandom_range(0, 5));
		else if (roll == 1)
			px.alpha = PIX_MAX;
		else
			px.alpha = pix_t'($urandom_range(0, 255));
		return px;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a burst with none.
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 11)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin : drive_b
		rgba_t nxt;
		if (start && !pix_taken) begin
			// Hold the item until the block takes it.
		end else if (gap_left != 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pixel_q.size() != 0) begin
			nxt = pixel_q.pop_front();
			red_in   <= nxt.red;
			green_in <= nxt.green;
			blue_in  <= nxt.blue;
			alpha_in <= nxt.alpha;
			start    <= 1'b1;
			gap_left <= pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin : watch_b
		rgba_t got;
		rgba_t want;
		rgba_t px;
		pix_taken <= start && !busy;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n && done === 1'b1) begin
			got = '{red_out, green_out, blue_out, alpha_out};
			if (restored_q.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, got);
				errors++;
			end else begin
				want = restored_q.pop_front();
				checked++;
				if (got.red !== want.red) begin
					$display("%0t: red expected %0d got %0d", $time, want.red, got.red);
					errors++;
				end
				if (got.green !== want.green) begin
					$display("%0t: green expected %0d got %0d", $time, want.green,
						got.green);
					errors++;
				end
				if (got.blue !== want.blue) begin
					$display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
					errors++;
				end
				if (got.alpha !== want.alpha) begin
					$display("%0t: alpha expected %0d got %0d", $time, want.alpha,
						got.alpha);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			px = '{red_in, green_in, blue_in, alpha_in};
			if (px.alpha < ALPHA_MIN)
				low_alpha++;
			restored_q.push_back(unmatte_pixel(px));
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			// Only the register's width is kept; unmapped indexes do nothing.
			case (cfg_index)
				REG_MATTE_MODE:   mode_cfg  = cfg_data[1:0];
				REG_CUSTOM_RED:   red_cfg   = cfg_data;
				REG_CUSTOM_GREEN: green_cfg = cfg_data;
				REG_CUSTOM_BLUE:  blue_cfg  = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("color_matte_removal_test NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the write.
	task automatic write_reg(logic [7:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(negedge clk);
		while (!cfg_taken);
	endtask

	// Checked at the rising edge, where start and the pending queue are settled.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || start || restored_q.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic push_random(int count);
		repeat (count) pixel_q.push_back(random_pixel());
	endtask

	initial begin : stim_b
		matte_setting_t settings[NUM_SETTINGS];
		settings[0] = '{MATTE_BLACK, 8'd0, 8'd0, 8'd0, 1'b0};
		settings[1] = '{MATTE_WHITE, 8'd0, 8'd0, 8'd0, 1'b0};
		settings[2] = '{MATTE_CUSTOM, 8'd0, 8'd0, 8'd0, 1'b0};
		settings[3] = '{MATTE_CUSTOM, 8'd255, 8'd255, 8'd255, 1'b0};
		settings[4] = '{MATTE_CUSTOM, pix_t'($urandom_range(0, 255)),
			pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)), 1'b0};
		// All ones on the mode register: only the low bits land, giving the spare mode.
		settings[5] = '{8'hFF, pix_t'($urandom_range(0, 255)),
			pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)), 1'b0};
		settings[6] = '{MATTE_CUSTOM, pix_t'($urandom_range(0, 255)),
			pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)), 1'b1};
		settings[7] = '{MATTE_BLACK, pix_t'($urandom_range(0, 255)),
			pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)), 1'b0};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			// The first setting runs on the reset values of the registers.
			if (s != 0) begin
				wait_drained();
				if (settings[s].poke_unmapped) begin
					write_reg(UNMAPPED_LOW, 8'hA5);
					write_reg(UNMAPPED_HIGH, 8'h5A);
				end
				write_reg(REG_MATTE_MODE, settings[s].mode_data);
				write_reg(REG_CUSTOM_RED, settings[s].red);
				write_reg(REG_CUSTOM_GREEN, settings[s].green);
				write_reg(REG_CUSTOM_BLUE, settings[s].blue);
				cfg_valid <= 1'b0;
			end
			// Corners: lowest alpha that divides, opaque, and pass-through alpha 2 (and 0 in the first two settings).
			pixel_q.push_back('{8'd255, 8'd0, 8'd128, 8'd3});
			pixel_q.push_back('{8'd0, 8'd255, 8'd1, 8'd255});
			pixel_q.push_back('{8'd200, 8'd17, 8'd255, 8'd2});
			if (s < 2)
				pixel_q.push_back('{8'd7, 8'd250, 8'd90, 8'd0});
			if (s == 4) begin
				push_random(RANDOM_PER_SET / 2);
				wait_drained();
				push_random(RANDOM_PER_SET - RANDOM_PER_SET / 2);
			end else begin
				push_random(RANDOM_PER_SET);
			end
		end

		wait_drained();
		repeat (OUT_LAT + 4) @(posedge clk);
		$display("Checked %0d pixels over %0d matte settings, %0d of them below the alpha floor.",
			checked, NUM_SETTINGS, low_alpha);
		if (errors == 0)
			$display("color_matte_removal_test OK");
		else
			$display("color_matte_removal_test NOT OK");
		$finish;
	end

endmodule
